>>> hdl/twga_pkg.sv
package twga_pkg;

  // Strip and table dimensions.
  localparam int LED_COUNT   = 30;
  localparam int TABLE_DEPTH = 256;
  localparam int TIDX_W      = $clog2(TABLE_DEPTH);

  // Field and state widths.
  localparam int LED_W  = 6;
  localparam int POS_W  = 23;
  localparam int VEL_W  = 22;
  localparam int PH_W   = 19;
  localparam int CFG_W  = 20;
  localparam int CIDX_W = 3;
  localparam int ROM_W  = 17;

  // Fixed-point constants in Q.16.
  localparam logic [PH_W-1:0]  Q16_TWO_PI   = PH_W'(411775);
  localparam logic [PH_W-1:0]  Q16_POINT3   = PH_W'(19661);
  localparam logic [POS_W-1:0] Q16_EDGE_GAP = POS_W'(66);
  localparam logic [POS_W-1:0] POS_TOP      = POS_W'(LED_COUNT * 65536);
  localparam logic [POS_W-1:0] POS_RESET    = POS_W'(LED_COUNT * 32768);

  // Reciprocal of two pi for the shimmer table index.
  localparam longint ANG_RECIP = (64'd1 << 32) / 411775;
  localparam logic [25:0] ANG_MUL = 26'(TABLE_DEPTH * ANG_RECIP);
  localparam logic [12:0] TD_C    = 13'(TABLE_DEPTH);

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_TILT_GAIN      = 3'd0;
  localparam logic [CIDX_W-1:0] REG_DRAG_FACTOR    = 3'd1;
  localparam logic [CIDX_W-1:0] REG_BOUNCE_DAMPING = 3'd2;
  localparam logic [CIDX_W-1:0] REG_VELOCITY_LIMIT = 3'd3;
  localparam logic [CIDX_W-1:0] REG_GLOW_DECAY     = 3'd4;
  localparam logic [CIDX_W-1:0] REG_PHASE_STEP     = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DRAG, ST_CLAMP, ST_EDGE,
    ST_LED_MUL, ST_LED_IDX, ST_LED_PROD, ST_LED_OUT
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE, OP_DRAG, OP_CLAMP, OP_EDGE,
    OP_LED_MUL, OP_LED_IDX, OP_LED_PROD, OP_LED_OUT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic in_ready;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic last_led;
  } status_t;

  typedef logic [ROM_W-1:0] rom_t [TABLE_DEPTH];

  // Exponential decay table over arguments [0, 8).
  function automatic rom_t build_exp_rom();
    rom_t   r;
    longint one31;
    longint y;
    longint term;
    longint sum;
    longint e;
    one31 = 64'sd1 <<< 31;
    y     = (64'sd8 <<< 31) / TABLE_DEPTH;
    term  = one31;
    sum   = one31;
    // Alternating series to the tenth power for the decay of one table step.
    term = (term * y) >>> 31;         sum = sum - term;
    term = ((term * y) >>> 31) / 2;   sum = sum + term;
    term = ((term * y) >>> 31) / 3;   sum = sum - term;
    term = ((term * y) >>> 31) / 4;   sum = sum + term;
    term = ((term * y) >>> 31) / 5;   sum = sum - term;
    term = ((term * y) >>> 31) / 6;   sum = sum + term;
    term = ((term * y) >>> 31) / 7;   sum = sum - term;
    term = ((term * y) >>> 31) / 8;   sum = sum + term;
    term = ((term * y) >>> 31) / 9;   sum = sum - term;
    term = ((term * y) >>> 31) / 10;  sum = sum + term;
    e = one31;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      r[k] = ROM_W'((e + 64'sd16384) >>> 15);
      e = (e * sum) >>> 31;
    end
    return r;
  endfunction

  // Shimmer table: 0.8 + 0.2 * sin over one turn, by rotation.
  function automatic rom_t build_shim_rom();
    rom_t   r;
    longint one30;
    longint t;
    longint t2;
    longint t3;
    longint t4;
    longint t5;
    longint t6;
    longint sn;
    longint cs;
    longint x;
    longint z;
    longint s;
    longint nx;
    longint nz;
    one30 = 64'sd1 <<< 30;
    t  = 64'sd6746518852 / TABLE_DEPTH;
    t2 = (t * t) >>> 30;
    t3 = (t2 * t) >>> 30;
    t4 = (t2 * t2) >>> 30;
    t5 = (t3 * t2) >>> 30;
    t6 = (t4 * t2) >>> 30;
    sn = t - t3 / 6 + t5 / 120;
    cs = one30 - t2 / 2 + t4 / 24 - t6 / 720;
    x  = one30;
    z  = 0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      s = 4 * one30 + z;
      if (s < 0) s = 0;
      r[k] = ROM_W'((s / 5 + 64'sd8192) >>> 14);
      nx = (x * cs - z * sn + (one30 >>> 1)) >>> 30;
      nz = (x * sn + z * cs + (one30 >>> 1)) >>> 30;
      x = nx;
      z = nz;
    end
    return r;
  endfunction

  localparam rom_t EXP_ROM  = build_exp_rom();
  localparam rom_t SHIM_ROM = build_shim_rom();

endpackage

>>> hdl/twga_in_if.sv
interface twga_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] tilt_sample;

  modport source (output valid, output tilt_sample, input ready);
  modport sink (input valid, input tilt_sample, output ready);
endinterface

>>> hdl/twga_out_if.sv
interface twga_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] led_index;
  logic [7:0] brightness;
  logic       last_led;

  modport source (output valid, output led_index, output brightness, output last_led,
                  input ready);
  modport sink (input valid, input led_index, input brightness, input last_led,
                output ready);
endinterface

>>> hdl/twga_ctrl.sv
module twga_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  twga_pkg::status_t status_i,
  output twga_pkg::cmd_t    cmd_o
);
  import twga_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state: physics steps, then four steps per LED.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (status_i.in_valid) state_d = ST_DRAG;
      ST_DRAG:     state_d = ST_CLAMP;
      ST_CLAMP:    state_d = ST_EDGE;
      ST_EDGE:     state_d = ST_LED_MUL;
      ST_LED_MUL:  state_d = ST_LED_IDX;
      ST_LED_IDX:  state_d = ST_LED_PROD;
      ST_LED_PROD: state_d = ST_LED_OUT;
      ST_LED_OUT: begin
        if (status_i.out_free) begin
          state_d = status_i.last_led ? ST_IDLE : ST_LED_MUL;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o = '{op: OP_NONE, in_ready: 1'b0, out_load: 1'b0};
    case (state_q)
      ST_IDLE:     cmd_o.in_ready = 1'b1;
      ST_DRAG:     cmd_o.op = OP_DRAG;
      ST_CLAMP:    cmd_o.op = OP_CLAMP;
      ST_EDGE:     cmd_o.op = OP_EDGE;
      ST_LED_MUL:  cmd_o.op = OP_LED_MUL;
      ST_LED_IDX:  cmd_o.op = OP_LED_IDX;
      ST_LED_PROD: cmd_o.op = OP_LED_PROD;
      ST_LED_OUT: begin
        cmd_o.op       = OP_LED_OUT;
        cmd_o.out_load = status_i.out_free;
      end
      default:     cmd_o.op = OP_NONE;
    endcase
  end

endmodule

>>> hdl/twga_dpath.sv
module twga_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [twga_pkg::CIDX_W-1:0]   cfg_index_i,
  input  logic [twga_pkg::CFG_W-1:0]    cfg_data_i,
  input  twga_pkg::cmd_t                cmd_i,
  output twga_pkg::status_t             status_o,
  twga_in_if.sink                       in_ch,
  twga_out_if.source                    out_ch
);
  import twga_pkg::*;

  logic [15:0] gain_q, drag_q, damp_q, decay_q, step_q;
  logic [19:0] lim_q;

  logic [POS_W-1:0]        mp_q;
  logic signed [VEL_W-1:0] mv_q;
  logic [PH_W-1:0]         phase_q;

  logic signed [32:0]      accel_prod_q;
  logic signed [40:0]      drag_prod_q;
  logic signed [VEL_W-1:0] vc_q;
  logic signed [24:0]      pos_sum_q;
  logic signed [39:0]      bounce_prod_q;

  logic [LED_W-1:0]  led_q;
  logic [PH_W-1:0]   ang_q;
  logic [38:0]       glow_prod_q;
  logic [47:0]       recip_prod_q;
  logic [ROM_W-1:0]  inten_q;
  logic [TIDX_W-1:0] sidx_q;
  logic [33:0]       prod_q;

  logic             out_valid_q;
  logic [LED_W-1:0] out_idx_q;
  logic [7:0]       out_bri_q;
  logic             out_last_q;

  logic                    accept;
  logic signed [23:0]      vel_sum;
  logic signed [24:0]      vel_sh;
  logic signed [24:0]      lim_s;
  logic signed [VEL_W-1:0] vc;
  logic signed [22:0]      vc_neg;
  logic [PH_W:0]           ph_sum;
  logic signed [VEL_W-1:0] bounce_v;
  logic signed [24:0]      dist_s;
  logic [POS_W-1:0]        dist_abs;
  logic [22:0]             arg;
  logic [35:0]             eprod;
  logic [16:0]             eidx;
  logic [15:0]             q0;
  logic [31:0]             ang_x;
  logic [31:0]             q0_mul;
  logic [31:0]             ang_rem;
  logic [15:0]             sidx;
  logic [41:0]             b_full;
  logic [9:0]              b_sh;
  logic [PH_W:0]           ang_sum;

  assign accept = in_ch.valid && cmd_i.in_ready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= 16'd13107;
      drag_q  <= 16'd64225;
      damp_q  <= 16'd55706;
      lim_q   <= 20'd65536;
      decay_q <= 16'd32768;
      step_q  <= 16'd3277;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TILT_GAIN:      gain_q  <= cfg_data_i[15:0];
        REG_DRAG_FACTOR:    drag_q  <= cfg_data_i[15:0];
        REG_BOUNCE_DAMPING: damp_q  <= cfg_data_i[15:0];
        REG_VELOCITY_LIMIT: lim_q   <= cfg_data_i;
        REG_GLOW_DECAY:     decay_q <= cfg_data_i[15:0];
        REG_PHASE_STEP:     step_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Physics arithmetic.
  always_comb begin
    vel_sum = 24'(mv_q) + 24'(accel_prod_q >>> 14);
    vel_sh  = drag_prod_q[40:16];
    lim_s   = $signed({5'd0, lim_q});
    if (vel_sh > lim_s) vc = VEL_W'(lim_s);
    else if (vel_sh < -lim_s) vc = VEL_W'(-lim_s);
    else vc = VEL_W'(vel_sh);
    vc_neg   = -(23'(vc));
    ph_sum   = {1'b0, phase_q} + (PH_W + 1)'(step_q);
    bounce_v = VEL_W'(bounce_prod_q[39:16]);
  end

  // Per-LED arithmetic.
  always_comb begin
    dist_s   = $signed({1'b0, led_q, 16'd0, 2'd0} >> 2) - $signed({2'b0, mp_q});
    dist_abs = dist_s[24] ? POS_W'(-dist_s) : POS_W'(dist_s);
    arg      = glow_prod_q[38:16];
    eprod    = 36'(arg) * 36'(TD_C);
    eidx     = eprod[35:19];
    q0       = recip_prod_q[47:32];
    ang_x    = 32'(ang_q) * 32'(TD_C);
    q0_mul   = 32'(q0) * 32'(Q16_TWO_PI);
    ang_rem  = ang_x - q0_mul;
    sidx     = (ang_rem >= 32'(Q16_TWO_PI)) ? q0 + 16'd1 : q0;
    b_full   = {prod_q, 8'd0} - 42'(prod_q);
    b_sh     = b_full[41:32];
    ang_sum  = {1'b0, ang_q} + {1'b0, Q16_POINT3};
  end

  // Mass state and shimmer phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mp_q    <= POS_RESET;
      mv_q    <= '0;
      phase_q <= '0;
    end else begin
      if (cmd_i.op == OP_CLAMP) begin
        phase_q <= (ph_sum >= {1'b0, Q16_TWO_PI}) ? PH_W'(ph_sum - {1'b0, Q16_TWO_PI})
                                                   : PH_W'(ph_sum);
      end
      if (cmd_i.op == OP_EDGE) begin
        if (pos_sum_q < 0) begin
          mp_q <= '0;
          mv_q <= bounce_v;
        end else if (pos_sum_q >= $signed({2'b0, POS_TOP})) begin
          mp_q <= POS_TOP - Q16_EDGE_GAP;
          mv_q <= bounce_v;
        end else begin
          mp_q <= POS_W'(pos_sum_q);
          mv_q <= vc_q;
        end
      end
    end
  end

  // Working registers of the physics and LED steps.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      accel_prod_q <= in_ch.tilt_sample * $signed({1'b0, gain_q});
    end
    case (cmd_i.op)
      OP_DRAG: drag_prod_q <= vel_sum * $signed({1'b0, drag_q});
      OP_CLAMP: begin
        vc_q          <= vc;
        pos_sum_q     <= $signed({2'b0, mp_q}) + 25'(vc);
        bounce_prod_q <= vc_neg * $signed({1'b0, damp_q});
      end
      OP_LED_MUL: begin
        glow_prod_q  <= 39'(dist_abs) * 39'(decay_q);
        recip_prod_q <= 48'(ang_q) * 48'(ANG_MUL);
      end
      OP_LED_IDX: begin
        inten_q <= (eidx < 17'(TD_C)) ? EXP_ROM[eidx[TIDX_W-1:0]] : '0;
        sidx_q  <= sidx[TIDX_W-1:0];
      end
      OP_LED_PROD: prod_q <= 34'(inten_q) * 34'(SHIM_ROM[sidx_q]);
      default: ;
    endcase
  end

  // LED counter and shimmer angle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_q <= '0;
      ang_q <= '0;
    end else if (cmd_i.op == OP_EDGE) begin
      led_q <= '0;
      ang_q <= phase_q;
    end else if (cmd_i.out_load) begin
      led_q <= led_q + LED_W'(1);
      ang_q <= (ang_sum >= {1'b0, Q16_TWO_PI}) ? PH_W'(ang_sum - {1'b0, Q16_TWO_PI})
                                                : PH_W'(ang_sum);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_idx_q  <= led_q;
      out_bri_q  <= (b_sh > 10'd255) ? 8'd255 : b_sh[7:0];
      out_last_q <= (led_q == LED_W'(LED_COUNT - 1));
    end
  end

  assign in_ch.ready      = cmd_i.in_ready;
  assign out_ch.valid     = out_valid_q;
  assign out_ch.led_index = out_idx_q;
  assign out_ch.brightness = out_bri_q;
  assign out_ch.last_led  = out_last_q;

  assign status_o.in_valid = in_ch.valid;
  assign status_o.out_free = !out_valid_q || out_ch.ready;
  assign status_o.last_led = (led_q == LED_W'(LED_COUNT - 1));

endmodule

>>> hdl/tilt_water_glow_animator.sv
// Tilt water glow animator. Each accepted request carries one tilt sample and
// starts a frame: the mass velocity and position are updated with drag, a
// velocity limit and damped bounces at the strip ends, the shimmer phase is
// advanced, and then one brightness request per LED is issued, LED 0 first,
// with last_led set on the final LED. A frame runs the drag, clamp and edge
// steps, then the shared multiply, table-index, table-product and output
// steps for each LED in turn; the output step waits while the output
// register is full. A new tilt sample is taken once the final LED has been
// loaded into the output register. Configuration writes are taken at any
// time and should only be made while no frame is being worked on.
module tilt_water_glow_animator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  twga_in_if.sink                     in_ch,
  twga_out_if.source                  out_ch,
  input  logic                        cfg_we_i,
  input  logic [twga_pkg::CIDX_W-1:0] cfg_index_i,
  input  logic [twga_pkg::CFG_W-1:0]  cfg_data_i
);
  import twga_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  twga_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Arithmetic, state and output register.
  twga_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

endmodule

>>> bench/testbench.sv
module testbench;
  import twga_pkg::*;

  // Spare register index: writes to it must leave every register unchanged.
  localparam logic [CIDX_W-1:0] REG_SPARE = 3'd6;
  localparam logic [CIDX_W-1:0] REG_TOP   = 3'd7;
  localparam int STALL_LIMIT  = 5000;
  localparam int SETTLE_CYCLES = 200;

  // Frame predictor: mirrors the registers and the mass state, and holds the
  // LED requests still owed by the block.
  class glow_frame_board;
    longint exp_tab[TABLE_DEPTH];
    longint shim_tab[TABLE_DEPTH];
    longint gain, drag, damping, vlimit, decay, pstep;
    longint pos, vel, phase;
    logic [5:0] led_q[$];
    logic [7:0] glow_q[$];
    logic       last_q[$];
    int fails;

    function new();
      longint one31, one30, y, term, sum, e;
      longint t, t2, t3, t4, t5, t6, sn, cs, x, z, s, nx, nz;
      one31 = 64'sd1 <<< 31;
      one30 = 64'sd1 <<< 30;
      // Decay table: e^-(8/depth) by a series to the tenth power, then repeated products.
      y = (64'sd8 <<< 31) / TABLE_DEPTH;
      term = one31;
      sum = one31;
      for (int n = 1; n <= 10; n++) begin
        term = ((term * y) >>> 31) / n;
        sum = (n % 2 == 1) ? sum - term : sum + term;
      end
      e = one31;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        exp_tab[k] = (e + 64'sd16384) >>> 15;
        e = (e * sum) >>> 31;
      end
      // Shimmer table: the sine is stepped round the circle by a fixed rotation.
      t  = 64'sd6746518852 / TABLE_DEPTH;
      t2 = (t * t) >>> 30;
      t3 = (t2 * t) >>> 30;
      t4 = (t2 * t2) >>> 30;
      t5 = (t3 * t2) >>> 30;
      t6 = (t4 * t2) >>> 30;
      sn = t - t3 / 6 + t5 / 120;
      cs = one30 - t2 / 2 + t4 / 24 - t6 / 720;
      x = one30;
      z = 0;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        s = 4 * one30 + z;
        if (s < 0) s = 0;
        shim_tab[k] = (s / 5 + 64'sd8192) >>> 14;
        nx = (x * cs - z * sn + (one30 >>> 1)) >>> 30;
        nz = (x * sn + z * cs + (one30 >>> 1)) >>> 30;
        x = nx;
        z = nz;
      end
      gain = 13107; drag = 64225; damping = 55706;
      vlimit = 65536; decay = 32768; pstep = 3277;
      pos = LED_COUNT * 32768;
      vel = 0;
      phase = 0;
      fails = 0;
    endfunction

    function void set_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_TILT_GAIN:      gain = val[15:0];
        REG_DRAG_FACTOR:    drag = val[15:0];
        REG_BOUNCE_DAMPING: damping = val[15:0];
        REG_VELOCITY_LIMIT: vlimit = val;
        REG_GLOW_DECAY:     decay = val[15:0];
        REG_PHASE_STEP:     pstep = val[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return led_q.size();
    endfunction

    // One accepted tilt request: advance the physics and queue the whole frame.
    function void note_tilt(logic signed [15:0] tilt);
      longint d, arg, eidx, inten, ang, sidx, b;
      vel = vel + ((longint'(tilt) * gain) >>> 14);
      vel = (vel * drag) >>> 16;
      if (vel > vlimit) vel = vlimit;
      if (vel < -vlimit) vel = -vlimit;
      pos = pos + vel;
      if (pos < 0) begin
        pos = 0;
        vel = (-vel * damping) >>> 16;
      end else if (pos >= LED_COUNT * 65536) begin
        pos = LED_COUNT * 65536 - 66;
        vel = (-vel * damping) >>> 16;
      end
      phase = phase + pstep;
      if (phase >= 411775) phase = phase - 411775;
      for (int i = 0; i < LED_COUNT; i++) begin
        d = (longint'(i) <<< 16) - pos;
        if (d < 0) d = -d;
        arg = (d * decay) >>> 16;
        eidx = (arg * TABLE_DEPTH) >>> 19;
        inten = (eidx < TABLE_DEPTH) ? exp_tab[eidx] : 0;
        ang = (i * 19661 + phase) % 411775;
        sidx = (ang * TABLE_DEPTH / 411775) % TABLE_DEPTH;
        b = (inten * shim_tab[sidx] * 255) >>> 32;
        if (b > 255) b = 255;
        led_q.push_back(6'(i));
        glow_q.push_back(8'(b));
        last_q.push_back(i == LED_COUNT - 1);
      end
    endfunction

    function void check_led(logic [5:0] led, logic [7:0] glow, logic last);
      logic [5:0] exp_led;
      logic [7:0] exp_glow;
      logic       exp_last;
      if (led_q.size() == 0) begin
        $error("unexpected LED request: led_index %0d", led);
        fails++;
        return;
      end
      exp_led = led_q.pop_front();
      exp_glow = glow_q.pop_front();
      exp_last = last_q.pop_front();
      if (led !== exp_led) begin
        $error("led_index: expected %0d, got %0d", exp_led, led);
        fails++;
      end
      if (glow !== exp_glow) begin
        $error("brightness: expected %0d, got %0d", exp_glow, glow);
        fails++;
      end
      if (last !== exp_last) begin
        $error("last_led: expected %0d, got %0d", exp_last, last);
        fails++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CIDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]  cfg_data_i;
  int in_idle;
  int out_idle;
  int quiet_cycles;
  glow_frame_board board;

  twga_in_if  in_ch();
  twga_out_if out_ch();

  tilt_water_glow_animator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // The receiver stalls at random, changing ready on the falling edge.
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= out_idle);
  end

  // Results are checked on the rising edge at which they are taken.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      board.check_led(out_ch.led_index, out_ch.brightness, out_ch.last_led);
  end

  // Watchdog on cycles in which no request moves on either side.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offers one tilt request, after a random number of idle cycles.
  task automatic send_tilt(input logic signed [15:0] tilt);
    while ($urandom_range(99) < in_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.tilt_sample <= tilt;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_tilt(tilt);
    @(negedge clk_i);
  endtask

  // Lets every owed LED request arrive before the registers are touched.
  task automatic drain_frames();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (board.pending() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    board.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(input logic [CFG_W-1:0] g, input logic [CFG_W-1:0] dr,
                           input logic [CFG_W-1:0] bd, input logic [CFG_W-1:0] vl,
                           input logic [CFG_W-1:0] dc, input logic [CFG_W-1:0] ps);
    drain_frames();
    write_reg(REG_TILT_GAIN, g);
    write_reg(REG_DRAG_FACTOR, dr);
    write_reg(REG_BOUNCE_DAMPING, bd);
    write_reg(REG_VELOCITY_LIMIT, vl);
    write_reg(REG_GLOW_DECAY, dc);
    write_reg(REG_PHASE_STEP, ps);
  endtask

  initial begin
    board = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.tilt_sample = '0;
    out_ch.ready = 1'b0;
    quiet_cycles = 0;
    in_idle = 34;
    out_idle = 34;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings with the tilt extremes and small values.
    send_tilt(16'sh7fff);
    send_tilt(-16'sd32768);
    send_tilt(16'sd0);
    send_tilt(16'sd1);
    send_tilt(-16'sd1);

    // Writes to indexes beyond the register list must change nothing.
    drain_frames();
    write_reg(REG_SPARE, '1);
    write_reg(REG_TOP, '0);
    send_tilt(16'sd4096);

    // Full gain and no drag loss: drive the mass into the high end, then the low.
    write_all(20'hffff, 20'hffff, 20'hffff, 20'hfffff, 20'hffff, 20'hffff);
    repeat (4) send_tilt(16'sh7fff);
    repeat (5) send_tilt(-16'sd32768);
    // Zero limit, damping, decay and phase step.
    write_all(20'hffff, 20'hffff, 20'h0, 20'h0, 20'h0, 20'h0);
    send_tilt(16'sh7fff);
    send_tilt(-16'sd32768);
    write_all(20'hffff, 20'h8000, 20'h0, 20'h30000, 20'h2000, 20'h8000);
    repeat (4) send_tilt(-16'sd32768);
    repeat (2) send_tilt(16'sh7fff);

    // Random phases with random settings; one long stretch has no idling.
    for (int ph = 0; ph < 5; ph++) begin
      write_all(CFG_W'($urandom_range(65535)), CFG_W'($urandom_range(65535)),
                CFG_W'($urandom_range(65535)), CFG_W'($urandom_range(1048575)),
                CFG_W'($urandom_range(65535)), CFG_W'($urandom_range(65535)));
      in_idle = (ph == 2) ? 0 : 34;
      out_idle = (ph == 2) ? 0 : 34;
      for (int k = 0; k < 15; k++) send_tilt(16'($urandom));
    end
    in_idle = 34;
    out_idle = 34;
    write_all(20'd13107, 20'd64225, 20'd55706, 20'd65536, 20'd32768, 20'd3277);
    for (int k = 0; k < 6; k++) send_tilt(16'($urandom));

    drain_frames();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (board.fails == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> files.f
hdl/twga_pkg.sv
hdl/twga_in_if.sv
hdl/twga_out_if.sv
hdl/twga_ctrl.sv
hdl/twga_dpath.sv
hdl/tilt_water_glow_animator.sv
bench/testbench.sv
